/* rtl/scfb_pkg.sv */
// ----------------------------------------------------------------------------
// scfb_pkg
// Shared types, constants and helpers for the system-exclusive frame builder.
// ----------------------------------------------------------------------------
package scfb_pkg;

  // Frame framing bytes
  localparam logic [7:0] SYX_START = 8'hF0;
  localparam logic [7:0] MAKER_ID  = 8'h41;
  localparam logic [7:0] MODEL_ID  = 8'h33;
  localparam logic [7:0] SYX_END   = 8'hF7;

  // Command codes
  localparam logic [7:0] CMD_DATA_SET = 8'h12;
  localparam logic [7:0] CMD_DATA_REQ = 8'h11;

  // Checksum arithmetic
  localparam logic [6:0] SUM_MASK = 7'h7F;

  // Frame layout: header (7) + command (1) + address (4) + checksum + end
  localparam int HDR_LEN        = 7;
  localparam int CMD_POS        = 7;
  localparam int ADDR_POS       = 8;
  localparam int PAYLOAD_POS    = 12;
  localparam int FRAME_BASE_LEN = 14;
  localparam int FRAME_MAX      = 18;
  localparam int POS_W          = 5;

  // Payload byte count limit
  localparam int MAX_PAYLOAD_BYTES_DEF = 4;
  localparam int PAYLOAD_WORD_BYTES    = 4;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // One classified command, as handed from front to back
  typedef struct packed {
    logic [31:0] target_address;
    logic [7:0]  command_code;
    logic [31:0] payload_aligned;  // first sent byte in bits 31:24
    logic [2:0]  payload_bytes;    // saturated count
    logic [6:0]  checksum;
  } scfb_desc_t;

  // Header byte at a position below HDR_LEN
  function automatic logic [7:0] header_byte(input logic [2:0] pos);
    logic [7:0] b;
    unique case (pos)
      3'd0:    b = SYX_START;
      3'd1:    b = MAKER_ID;
      3'd6:    b = MODEL_ID;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Byte sel of a 32-bit word, most significant first
  function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] sel);
    logic [7:0] b;
    unique case (sel)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

endpackage

/* rtl/scfb_front.sv */
// ----------------------------------------------------------------------------
// scfb_front
// Command intake: saturates the payload count, aligns the payload bytes and
// forms the checksum, then hands a descriptor to the command queue.
// ----------------------------------------------------------------------------
module scfb_front
  import scfb_pkg::*;
#(
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_target_address,
  input  logic [7:0]  in_command_code,
  input  logic [31:0] in_payload_word,
  input  logic [2:0]  in_payload_bytes,
  input  logic        q_full,
  output logic        q_push,
  output scfb_desc_t  q_desc
);

  localparam logic [2:0] MAX_N = 3'(MAX_PAYLOAD_BYTES);

  logic [2:0]  n_sat;
  logic [5:0]  shamt;
  logic [31:0] aligned;
  logic [6:0]  acc;

  // Accept a beat whenever the queue has room
  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  // Saturate the count and left-align the sent payload bytes
  always_comb begin
    n_sat   = (in_payload_bytes > MAX_N) ? MAX_N : in_payload_bytes;
    shamt   = {3'(3'(PAYLOAD_WORD_BYTES) - n_sat), 3'b000};
    aligned = in_payload_word << shamt;
  end

  // Sum address and payload bytes modulo 128 (unsent bytes are zero)
  always_comb begin
    acc = 7'(in_target_address[31:24]) + 7'(in_target_address[23:16])
        + 7'(in_target_address[15:8])  + 7'(in_target_address[7:0])
        + 7'(aligned[31:24]) + 7'(aligned[23:16])
        + 7'(aligned[15:8])  + 7'(aligned[7:0]);
  end

  // Build the descriptor
  always_comb begin
    q_desc.target_address  = in_target_address;
    q_desc.command_code    = in_command_code;
    q_desc.payload_aligned = aligned;
    q_desc.payload_bytes   = n_sat;
    q_desc.checksum        = (7'd0 - acc) & SUM_MASK;
  end

endmodule

/* rtl/scfb_queue.sv */
// ----------------------------------------------------------------------------
// scfb_queue
// Short descriptor queue that decouples command intake from frame emission.
// ----------------------------------------------------------------------------
module scfb_queue
  import scfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  scfb_desc_t push_desc,
  output logic       full,
  input  logic       pop,
  output logic       valid,
  output scfb_desc_t head_desc
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  scfb_desc_t       mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign valid     = (count_r != '0);
  assign head_desc = mem[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming descriptor
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

endmodule

/* rtl/scfb_back.sv */
// ----------------------------------------------------------------------------
// scfb_back
// Frame serialiser: walks the head descriptor one byte per beat into a
// registered output stage, and releases the descriptor on the closing byte.
// ----------------------------------------------------------------------------
module scfb_back
  import scfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  scfb_desc_t q_desc,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_frame_byte,
  output logic       out_frame_last
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       byte_r;
  logic             last_r;
  logic [POS_W-1:0] chk_pos;
  logic [POS_W-1:0] end_pos;
  logic             advance;
  logic             is_last;
  logic [7:0]       cur_byte;

  assign out_empty      = !out_valid_r;
  assign out_frame_byte = byte_r;
  assign out_frame_last = last_r;

  // Step when a command waits and the output stage is free or draining
  assign advance = q_valid && (!out_valid_r || out_pop);
  assign chk_pos = POS_W'(PAYLOAD_POS) + POS_W'(q_desc.payload_bytes);
  assign end_pos = chk_pos + 1'b1;
  assign is_last = (pos_r == end_pos);
  assign q_pop   = advance && is_last;

  // Select the byte at the current frame position
  always_comb begin
    if (pos_r < POS_W'(HDR_LEN)) begin
      cur_byte = header_byte(pos_r[2:0]);
    end else if (pos_r == POS_W'(CMD_POS)) begin
      cur_byte = q_desc.command_code;
    end else if (pos_r < POS_W'(PAYLOAD_POS)) begin
      cur_byte = word_byte(q_desc.target_address, pos_r[1:0]);
    end else if (pos_r < chk_pos) begin
      cur_byte = word_byte(q_desc.payload_aligned, pos_r[1:0]);
    end else if (pos_r == chk_pos) begin
      cur_byte = {1'b0, q_desc.checksum};
    end else begin
      cur_byte = SYX_END;
    end
  end

  // Advance the position, wrap at the end of the frame
  always_comb begin
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      pos_nxt       = is_last ? '0 : pos_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the output beat until it is taken
  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r <= cur_byte;
      last_r <= is_last;
    end
  end

endmodule

/* rtl/sysex_command_frame_builder_top.sv */
// A taken command is written into the queue; its first frame byte then comes from the registered output stage.
// Each command gives 14 + payload_bytes output beats, one per cycle while out_pop
//   takes every byte; the byte serialiser sets the rate at which commands drain.
// A two-entry command queue lets intake continue while a frame is sent.
// Reset (synchronous, rst_n low) empties the queue and the output stage.
// ----------------------------------------------------------------------------
// sysex_command_frame_builder_top
// Builds a system-exclusive command frame with checksum and sends it bytewise.
// ----------------------------------------------------------------------------
module sysex_command_frame_builder_top
  import scfb_pkg::*;
#(
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_target_address,
  input  logic [7:0]  in_command_code,
  input  logic [31:0] in_payload_word,
  input  logic [2:0]  in_payload_bytes,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_frame_byte,
  output logic        out_frame_last
);

  logic       q_push;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  scfb_desc_t push_desc;
  scfb_desc_t head_desc;

  // Intake and classification
  scfb_front #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_front (
    .in_push           (in_push),
    .in_full           (in_full),
    .in_target_address (in_target_address),
    .in_command_code   (in_command_code),
    .in_payload_word   (in_payload_word),
    .in_payload_bytes  (in_payload_bytes),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_desc            (push_desc)
  );

  // Command queue
  scfb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head_desc (head_desc)
  );

  // Frame serialiser
  scfb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_desc         (head_desc),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_frame_byte (out_frame_byte),
    .out_frame_last (out_frame_last)
  );

endmodule
